// File: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the payload widths, status codes and the cell-level types.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] priority_key;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spq_if.sv
// ---------------------------------------------------------------------------
// spq_if: word channels of the sorted priority queue
// Command channel and response channel, each with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [spq_pkg::DATA_W-1:0]   value;
    logic signed [spq_pkg::DATA_W-1:0]   priority_req;

    modport source (output valid, command, value, priority_req, input ready);
    modport sink   (input valid, command, value, priority_req, output ready);
endinterface

interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STATUS_W-1:0]        status;
    logic signed [spq_pkg::DATA_W-1:0]   pop_value;
    logic [spq_pkg::COUNT_W-1:0]         entry_count;
    logic                                queue_empty;

    modport source (output valid, status, pop_value, entry_count, queue_empty, input ready);
    modport sink   (input valid, status, pop_value, entry_count, queue_empty, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on push keeps, takes the new entry or shifts from the
// left neighbor; on pop takes the right neighbor's entry.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_stay,
    input  wire spq_pkg::entry_t    right_entry,
    input  wire logic               occupied,
    output logic                    stay,
    output spq_pkg::entry_t         entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Strictly higher priority holds its place; equal priorities yield.
    assign stay  = occupied && (entry_reg.priority_key > new_entry.priority_key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (stay)
                entry_next = entry_reg;
            else if (left_stay)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue, highest priority first
// A row of compare-and-shift cells keeps entries sorted; push inserts ahead
// of every entry of lower or equal priority, pop removes the head.
// ---------------------------------------------------------------------------
//  channel | dir | word fields
//  --------+-----+-------------------------------------------------------
//  cmd     | in  | command, value, priority_req
//  rsp     | out | status, pop_value, entry_count, queue_empty
//
//  One command word per cycle; its response word is registered and shows up
//  the cycle after acceptance. The figure is set by the cell row: every cell
//  compares and shifts in the same cycle. Reset clears the count and the
//  response valid flag, not its payload or the cell contents. A stalled
//  response holds cmd.ready low unless rsp is taken in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_cmd_if.sink    cmd,
    spq_rsp_if.source  rsp
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                               rsp_valid_reg;
    logic [spq_pkg::STATUS_W-1:0]       status_reg;
    logic [spq_pkg::STATUS_W-1:0]       status_next;
    logic signed [spq_pkg::DATA_W-1:0]  pop_value_reg;
    logic signed [spq_pkg::DATA_W-1:0]  pop_value_next;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     new_entry;
    logic [31:0]         count_wide;

    spq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_stay;
    logic [QUEUE_DEPTH-1:0] cell_occupied;

    // Take a new word whenever the response slot is free or being drained.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign new_entry.value        = cmd.value;
    assign new_entry.priority_key = cmd.priority_req;

    // Only accepted, legal commands move the cells.
    assign ctrl.push = accept && (cmd.command == spq_pkg::CMD_PUSH) && !is_full;
    assign ctrl.pop  = accept && (cmd.command == spq_pkg::CMD_POP) && !is_empty;

    // Cell row: cell 0 is the head; the sorted order makes cell_stay a prefix.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_stay;

        assign cell_occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            // Nothing ahead of the head: a non-staying head takes the new entry.
            assign left_entry = new_entry;
            assign left_stay  = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_stay  = cell_stay[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_stay   (left_stay),
            .right_entry (right_entry),
            .occupied    (cell_occupied[i]),
            .stay        (cell_stay[i]),
            .entry       (cell_entry[i])
        );
    end

    // Count update and response word for the accepted command.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = spq_pkg::ST_OK;
        pop_value_next = '0;
        if (cmd.command == spq_pkg::CMD_POP)
        begin
            if (is_empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                pop_value_next = cell_entry[0].value;
                count_next     = count_reg - CNT_W'(1);
            end
        end
        else
        begin
            if (is_full)
                status_next = spq_pkg::ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the response: hold until the next accepted command.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
        end
    end

    // Count after the item: count_reg already holds it once the word is valid.
    assign count_wide = 32'(count_reg);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.pop_value   = pop_value_reg;
    assign rsp.entry_count = count_wide[spq_pkg::COUNT_W-1:0];
    assign rsp.queue_empty = is_empty;

endmodule

`default_nettype wire
